// ===== src/rmp_pkg.sv =====
package rmp_pkg;

    // widths
    localparam int ENTRY_BITS = 16;
    localparam int LEAF_BITS  = 10;
    localparam int COUNT_BITS = 11;
    localparam int NODE_BITS  = 11;
    localparam int NODE_DEPTH = 2048;
    localparam int SUM_BITS   = 2 * ENTRY_BITS + 1;
    localparam int CNT_BITS   = 6;
    localparam int STK_DEPTH  = 16;
    localparam int STK_BITS   = 4;
    localparam int MAX_LEAVES = 1024;

    // 2x2 matrix, element 0 = top-left, 1 = top-right, 2 = bottom-left, 3 = bottom-right
    typedef logic [3:0][ENTRY_BITS-1:0] mat_t;

    localparam mat_t IDENT_MAT = {16'd1, 16'd0, 16'd0, 16'd1};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MODULUS    = 1'b0,
        CFG_LEAF_COUNT = 1'b1
    } cfg_idx_t;

    // input actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [LEAF_BITS-1:0]  leaf_index;
        logic [ENTRY_BITS-1:0] entry_00;
        logic [ENTRY_BITS-1:0] entry_01;
        logic [ENTRY_BITS-1:0] entry_10;
        logic [ENTRY_BITS-1:0] entry_11;
        logic [LEAF_BITS-1:0]  range_low;
        logic [LEAF_BITS-1:0]  range_high;
    } req_t;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] prod_00;
        logic [ENTRY_BITS-1:0] prod_01;
        logic [ENTRY_BITS-1:0] prod_10;
        logic [ENTRY_BITS-1:0] prod_11;
        logic                  status;
    } rsp_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_IDENT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 status;
        logic [LEAF_BITS-1:0] pos;
        logic [LEAF_BITS-1:0] lo;
        logic [LEAF_BITS-1:0] hi;
        mat_t                 mat;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDRED,
        ST_CALL,
        ST_RD,
        ST_RET,
        ST_LRD1,
        ST_LRD2,
        ST_MULW,
        ST_OUT
    } back_state_t;

endpackage

// ===== src/rmp_front.sv =====
module rmp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  rmp_pkg::req_t                 req,
    input  logic [rmp_pkg::COUNT_BITS-1:0] leaf_n,
    output logic                          q_valid,
    input  logic                          q_pop,
    output rmp_pkg::cmd_t                 q_cmd
);
    import rmp_pkg::*;

    cmd_t        ent_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        cls;
    logic        keep;
    logic        accept;
    logic        push;

    // classify the incoming item
    always_comb
    begin
        cls.kind   = CMD_QUERY;
        cls.status = 1'b0;
        cls.pos    = req.leaf_index;
        cls.lo     = req.range_low;
        cls.hi     = req.range_high;
        cls.mat    = {req.entry_11, req.entry_10, req.entry_01, req.entry_00};
        keep       = 1'b1;
        if (req.action == ACT_LOAD)
        begin
            cls.kind = CMD_LOAD;
            keep     = ({1'b0, req.leaf_index} < leaf_n);
        end
        else if (({1'b0, req.range_low} >= leaf_n) || ({1'b0, req.range_high} >= leaf_n))
        begin
            cls.kind   = CMD_IDENT;
            cls.status = 1'b1;
        end
        else if (req.range_low > req.range_high)
        begin
            cls.kind = CMD_IDENT;
        end
    end

    // two-entry queue toward the back end
    assign req_stall = (count_reg == 2'd2);
    assign accept    = req_valid && !req_stall;
    assign push      = accept && keep;
    assign q_valid   = (count_reg != 2'd0);
    assign q_cmd     = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== src/rmp_mul.sv =====
module rmp_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  rmp_pkg::mat_t                  a,
    input  rmp_pkg::mat_t                  b,
    input  logic [rmp_pkg::ENTRY_BITS-1:0] modulus,
    output logic                           done,
    output rmp_pkg::mat_t                  res
);
    import rmp_pkg::*;

    logic [SUM_BITS-1:0]     sum_reg [4];
    logic [SUM_BITS-1:0]     sum_in  [4];
    logic [2*ENTRY_BITS-1:0] pp      [8];
    logic [ENTRY_BITS-1:0]   rem_reg [4];
    logic [ENTRY_BITS-1:0]   rem_next [4];
    logic [CNT_BITS-1:0]     cnt_reg;
    logic                    run_reg;
    logic                    done_reg;

    // full-width entry products
    always_comb
    begin
        pp[0] = (2*ENTRY_BITS)'(a[0]) * (2*ENTRY_BITS)'(b[0]);
        pp[1] = (2*ENTRY_BITS)'(a[1]) * (2*ENTRY_BITS)'(b[2]);
        pp[2] = (2*ENTRY_BITS)'(a[0]) * (2*ENTRY_BITS)'(b[1]);
        pp[3] = (2*ENTRY_BITS)'(a[1]) * (2*ENTRY_BITS)'(b[3]);
        pp[4] = (2*ENTRY_BITS)'(a[2]) * (2*ENTRY_BITS)'(b[0]);
        pp[5] = (2*ENTRY_BITS)'(a[3]) * (2*ENTRY_BITS)'(b[2]);
        pp[6] = (2*ENTRY_BITS)'(a[2]) * (2*ENTRY_BITS)'(b[1]);
        pp[7] = (2*ENTRY_BITS)'(a[3]) * (2*ENTRY_BITS)'(b[3]);
    end

    // row times column sums, one per result entry
    always_comb
    begin
        sum_in[0] = {1'b0, pp[0]} + {1'b0, pp[1]};
        sum_in[1] = {1'b0, pp[2]} + {1'b0, pp[3]};
        sum_in[2] = {1'b0, pp[4]} + {1'b0, pp[5]};
        sum_in[3] = {1'b0, pp[6]} + {1'b0, pp[7]};
    end

    // one bit of restoring reduction per cycle for each entry
    always_comb
    begin
        logic [ENTRY_BITS:0] t;
        for (int i = 0; i < 4; i++)
        begin
            t = {rem_reg[i], sum_reg[i][SUM_BITS-1]};
            if (t >= {1'b0, modulus})
            begin
                t = t - {1'b0, modulus};
            end
            rem_next[i] = t[ENTRY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(SUM_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (start)
            begin
                sum_reg[i] <= sum_in[i];
                rem_reg[i] <= '0;
            end
            else if (run_reg)
            begin
                sum_reg[i] <= {sum_reg[i][SUM_BITS-2:0], 1'b0};
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            res[i] = rem_reg[i];
        end
    end

endmodule

// ===== src/rmp_back.sv =====
module rmp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rmp_pkg::ENTRY_BITS-1:0] mod_eff,
    input  logic [rmp_pkg::LEAF_BITS-1:0]  last_leaf,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  rmp_pkg::cmd_t                  q_cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output rmp_pkg::rsp_t                  rsp
);
    import rmp_pkg::*;

    back_state_t           state_reg, state_next;
    cmd_kind_t             kind_reg, kind_next;
    logic                  status_reg, status_next;
    logic [LEAF_BITS-1:0]  pos_reg, pos_next;
    logic [LEAF_BITS-1:0]  lo_reg, lo_next;
    logic [LEAF_BITS-1:0]  hi_reg, hi_next;
    mat_t                  x_reg, x_next;
    mat_t                  ret_reg, ret_next;
    mat_t                  tmp_reg, tmp_next;
    logic [NODE_BITS-1:0]  cur_v_reg, cur_v_next;
    logic [LEAF_BITS-1:0]  cur_l_reg, cur_l_next;
    logic [LEAF_BITS-1:0]  cur_r_reg, cur_r_next;
    logic [STK_BITS-1:0]   sp_reg, sp_next;
    logic                  out_vld_reg, out_vld_next;
    rsp_t                  out_reg, out_next;

    // call stack of interior nodes
    logic [NODE_BITS-1:0]  stk_v [STK_DEPTH];
    logic [LEAF_BITS-1:0]  stk_l [STK_DEPTH];
    logic [LEAF_BITS-1:0]  stk_r [STK_DEPTH];
    logic                  stk_ph [STK_DEPTH];
    mat_t                  stk_left [STK_DEPTH];
    logic                  push_en, setleft_en;
    logic [STK_BITS-1:0]   top_idx;
    logic [NODE_BITS-1:0]  t_v;
    logic [LEAF_BITS-1:0]  t_l, t_r, t_mid;
    logic [LEAF_BITS:0]    t_sum, c_sum;
    logic [LEAF_BITS-1:0]  c_mid;

    // node memory
    mat_t                  mem [NODE_DEPTH];
    logic                  mem_we, mem_re;
    logic [NODE_BITS-1:0]  mem_wa, mem_ra;
    mat_t                  mem_wd;
    mat_t                  rd_data_reg;

    // shared combine unit
    logic                  mul_start, mul_done;
    mat_t                  mul_a, mul_b, mul_res;

    rmp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .modulus (mod_eff),
        .done    (mul_done),
        .res     (mul_res)
    );

    assign top_idx = sp_reg - 1'b1;
    assign t_v     = stk_v[top_idx];
    assign t_l     = stk_l[top_idx];
    assign t_r     = stk_r[top_idx];
    assign t_sum   = {1'b0, t_l} + {1'b0, t_r};
    assign t_mid   = t_sum[LEAF_BITS:1];
    assign c_sum   = {1'b0, cur_l_reg} + {1'b0, cur_r_reg};
    assign c_mid   = c_sum[LEAF_BITS:1];

    // sequencer: walks the tree as the recursive descent would
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        x_next       = x_reg;
        ret_next     = ret_reg;
        tmp_next     = tmp_reg;
        cur_v_next   = cur_v_reg;
        cur_l_next   = cur_l_reg;
        cur_r_next   = cur_r_reg;
        sp_next      = sp_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && rsp_stall;
        q_pop        = 1'b0;
        push_en      = 1'b0;
        setleft_en   = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = cur_v_reg;
        mem_wd       = x_reg;
        mem_re       = 1'b0;
        mem_ra       = cur_v_reg;
        mul_start    = 1'b0;
        mul_a        = stk_left[top_idx];
        mul_b        = ret_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    kind_next   = q_cmd.kind;
                    status_next = q_cmd.status;
                    pos_next    = q_cmd.pos;
                    lo_next     = q_cmd.lo;
                    hi_next     = q_cmd.hi;
                    cur_v_next  = NODE_BITS'(1);
                    cur_l_next  = '0;
                    cur_r_next  = last_leaf;
                    sp_next     = '0;
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = q_cmd.mat;
                            mul_b      = IDENT_MAT;
                            state_next = ST_LDRED;
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_CALL;
                        end
                        default:
                        begin
                            ret_next   = IDENT_MAT;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_LDRED:
            begin
                if (mul_done)
                begin
                    x_next     = mul_res;
                    state_next = ST_CALL;
                end
            end
            ST_CALL:
            begin
                if (kind_reg == CMD_LOAD)
                begin
                    if (cur_l_reg == cur_r_reg)
                    begin
                        mem_we     = 1'b1;
                        state_next = ST_RET;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + 1'b1;
                        if (pos_reg <= c_mid)
                        begin
                            cur_v_next = {cur_v_reg[NODE_BITS-2:0], 1'b0};
                            cur_r_next = c_mid;
                        end
                        else
                        begin
                            cur_v_next = {cur_v_reg[NODE_BITS-2:0], 1'b1};
                            cur_l_next = c_mid + 1'b1;
                        end
                    end
                end
                else if (cur_l_reg > hi_reg || cur_r_reg < lo_reg)
                begin
                    ret_next   = IDENT_MAT;
                    state_next = ST_RET;
                end
                else if (cur_l_reg >= lo_reg && cur_r_reg <= hi_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    push_en    = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    cur_v_next = {cur_v_reg[NODE_BITS-2:0], 1'b0};
                    cur_r_next = c_mid;
                end
            end
            ST_RD:
            begin
                ret_next   = rd_data_reg;
                state_next = ST_RET;
            end
            ST_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = (kind_reg == CMD_LOAD) ? ST_IDLE : ST_OUT;
                end
                else if (kind_reg == CMD_LOAD)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = {t_v[NODE_BITS-2:0], 1'b0};
                    state_next = ST_LRD1;
                end
                else if (!stk_ph[top_idx])
                begin
                    setleft_en = 1'b1;
                    cur_v_next = {t_v[NODE_BITS-2:0], 1'b1};
                    cur_l_next = t_mid + 1'b1;
                    cur_r_next = t_r;
                    state_next = ST_CALL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MULW;
                end
            end
            ST_LRD1:
            begin
                tmp_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_ra     = {t_v[NODE_BITS-2:0], 1'b1};
                state_next = ST_LRD2;
            end
            ST_LRD2:
            begin
                mul_start  = 1'b1;
                mul_a      = tmp_reg;
                mul_b      = rd_data_reg;
                state_next = ST_MULW;
            end
            ST_MULW:
            begin
                if (mul_done)
                begin
                    if (kind_reg == CMD_LOAD)
                    begin
                        mem_we = 1'b1;
                        mem_wa = t_v;
                        mem_wd = mul_res;
                    end
                    else
                    begin
                        ret_next = mul_res;
                    end
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_RET;
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg)
                begin
                    out_next.prod_00 = ret_reg[0];
                    out_next.prod_01 = ret_reg[1];
                    out_next.prod_10 = ret_reg[2];
                    out_next.prod_11 = ret_reg[3];
                    out_next.status  = status_reg;
                    out_vld_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= CMD_LOAD;
            sp_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            sp_reg      <= sp_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        x_reg      <= x_next;
        ret_reg    <= ret_next;
        tmp_reg    <= tmp_next;
        cur_v_reg  <= cur_v_next;
        cur_l_reg  <= cur_l_next;
        cur_r_reg  <= cur_r_next;
        out_reg    <= out_next;
    end

    // stack writes
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stk_v[sp_reg]  <= cur_v_reg;
            stk_l[sp_reg]  <= cur_l_reg;
            stk_r[sp_reg]  <= cur_r_reg;
            stk_ph[sp_reg] <= 1'b0;
        end
        if (setleft_en)
        begin
            stk_left[top_idx] <= ret_reg;
            stk_ph[top_idx]   <= 1'b1;
        end
    end

    // node memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

// ===== src/range_matrix_product_mod_unit.sv =====
// Range product of 2x2 matrices modulo a configurable modulus, kept in a
// segment tree of up to 1024 leaves (2048 nodes in one memory).
// req channel (req_valid / req_stall / req): an item either loads one leaf
// matrix (entries reduced mod modulus, then the leaf-to-root path rebuilt) or
// asks the ordered product of leaves range_low..range_high.
// rsp channel (rsp_valid / rsp_stall / rsp): one item per query, none per load.
// Out-of-range query indexes give the identity with status 1; an empty range
// gives the identity with status 0. Loads beyond leaf_count are dropped.
// Config port (cfg_write / cfg_index / cfg_data): 0 = modulus, 1 = leaf_count;
// write only while the block is idle.
// Combines: every node combine goes through one shared 8-multiplier unit that
// reduces one bit per cycle. A load reduces the leaf entries in one combine,
// then does one combine per level back up to the root (depth = levels from the
// root to the leaf, at most ceil(log2 leaf_count)); a query does one combine
// per partly covered node that it visits, up to roughly 2 * depth combines.
// Items queue two deep in the front while the back end works.
// Reset: modulus 65535, leaf_count 1024, queues and result register empty;
// node contents are undefined until loaded. A stalled result is held in the
// output register; the back end holds the next result until it has been taken.
module range_matrix_product_mod_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  rmp_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output rmp_pkg::rsp_t                  rsp,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [rmp_pkg::ENTRY_BITS-1:0] cfg_data
);
    import rmp_pkg::*;

    logic [ENTRY_BITS-1:0] modulus_reg;
    logic [COUNT_BITS-1:0] leaf_count_reg;
    logic [ENTRY_BITS-1:0] mod_eff;
    logic [COUNT_BITS-1:0] leaf_n;
    logic [COUNT_BITS-1:0] leaf_n_m1;
    logic                  q_valid, q_pop;
    cmd_t                  q_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= ENTRY_BITS'(65535);
            leaf_count_reg <= COUNT_BITS'(MAX_LEAVES);
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
            else
            begin
                leaf_count_reg <= cfg_data[COUNT_BITS-1:0];
            end
        end
    end

    // effective modulus and clamped leaf count
    assign mod_eff   = (modulus_reg == '0) ? ENTRY_BITS'(1) : modulus_reg;
    assign leaf_n    = (leaf_count_reg == '0) ? COUNT_BITS'(1) :
                       (leaf_count_reg > COUNT_BITS'(MAX_LEAVES)) ? COUNT_BITS'(MAX_LEAVES) :
                       leaf_count_reg;
    assign leaf_n_m1 = leaf_n - 1'b1;

    rmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .leaf_n    (leaf_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    rmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mod_eff   (mod_eff),
        .last_leaf (leaf_n_m1[LEAF_BITS-1:0]),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== test/range_matrix_product_mod_checker.sv =====
`timescale 1ns / 1ps

module range_matrix_product_mod_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  rmp_pkg::req_t                  req,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  rmp_pkg::rsp_t                  rsp,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [rmp_pkg::ENTRY_BITS-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);
    import rmp_pkg::*;

    typedef struct packed {
        logic [15:0] m00;
        logic [15:0] m01;
        logic [15:0] m10;
        logic [15:0] m11;
    } quad_t;

    typedef struct packed {
        quad_t prod;
        logic  status;
    } answer_t;

    localparam quad_t UNIT = '{m00: 16'd1, m01: 16'd0, m10: 16'd0, m11: 16'd1};

    quad_t   tree_nodes [0:4095];
    int      cur_mod;
    int      cur_leaves;
    answer_t answer_fifo [$];

    function automatic longint unsigned mod_eff();
        return (cur_mod == 0) ? 1 : cur_mod;
    endfunction

    function automatic quad_t quad_mul(quad_t a, quad_t b);
        longint unsigned m;
        quad_t c;
        m = mod_eff();
        c.m00 = 16'((longint'(a.m00) * b.m00 + longint'(a.m01) * b.m10) % m);
        c.m01 = 16'((longint'(a.m00) * b.m01 + longint'(a.m01) * b.m11) % m);
        c.m10 = 16'((longint'(a.m10) * b.m00 + longint'(a.m11) * b.m10) % m);
        c.m11 = 16'((longint'(a.m10) * b.m01 + longint'(a.m11) * b.m11) % m);
        return c;
    endfunction

    // rebuild the leaf-to-root path after a leaf write
    function automatic void store_leaf(int v, int l, int r, int pos, quad_t x);
        int mid;
        if (l == r)
        begin
            tree_nodes[v] = x;
            return;
        end
        mid = (l + r) / 2;
        if (pos <= mid)
            store_leaf(2 * v, l, mid, pos, x);
        else
            store_leaf(2 * v + 1, mid + 1, r, pos, x);
        tree_nodes[v] = quad_mul(tree_nodes[2 * v], tree_nodes[2 * v + 1]);
    endfunction

    function automatic quad_t span_product(int v, int l, int r, int a, int b);
        int mid;
        if (l > b || r < a)
            return UNIT;
        if (l >= a && r <= b)
            return tree_nodes[v];
        mid = (l + r) / 2;
        return quad_mul(span_product(2 * v, l, mid, a, b),
                        span_product(2 * v + 1, mid + 1, r, a, b));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quad_t   x;
        answer_t ans;
        answer_t got;
        int      n;
        if (!rst_n)
        begin
            cur_mod    = 65535;
            cur_leaves = 1024;
            errors     = 0;
            answer_fifo.delete();
            pending    = 0;
        end
        else
        begin
            // register writes
            if (cfg_write)
            begin
                if (cfg_index == CFG_MODULUS)
                    cur_mod = cfg_data;
                else
                begin
                    n = cfg_data & 16'h7FF;
                    if (n == 0)
                        n = 1;
                    if (n > MAX_LEAVES)
                        n = MAX_LEAVES;
                    cur_leaves = n;
                end
            end
            // incoming item
            if (req_valid && !req_stall)
            begin
                if (req.action == ACT_LOAD)
                begin
                    if (req.leaf_index < cur_leaves)
                    begin
                        x.m00 = 16'(req.entry_00 % mod_eff());
                        x.m01 = 16'(req.entry_01 % mod_eff());
                        x.m10 = 16'(req.entry_10 % mod_eff());
                        x.m11 = 16'(req.entry_11 % mod_eff());
                        store_leaf(1, 0, cur_leaves - 1, req.leaf_index, x);
                    end
                end
                else
                begin
                    ans.status = 1'b0;
                    if (req.range_low >= cur_leaves || req.range_high >= cur_leaves)
                    begin
                        ans.prod   = UNIT;
                        ans.status = 1'b1;
                    end
                    else if (req.range_low > req.range_high)
                        ans.prod = UNIT;
                    else
                        ans.prod = span_product(1, 0, cur_leaves - 1,
                                                req.range_low, req.range_high);
                    answer_fifo = {answer_fifo, ans};
                end
            end
            // outgoing item
            if (rsp_valid && !rsp_stall)
            begin
                if (answer_fifo.size() == 0)
                begin
                    $error("unexpected result item");
                    errors++;
                end
                else
                begin
                    got = answer_fifo.pop_front();
                    if (rsp.prod_00 !== got.prod.m00)
                    begin
                        $error("prod_00 expected %0d actual %0d", got.prod.m00, rsp.prod_00);
                        errors++;
                    end
                    if (rsp.prod_01 !== got.prod.m01)
                    begin
                        $error("prod_01 expected %0d actual %0d", got.prod.m01, rsp.prod_01);
                        errors++;
                    end
                    if (rsp.prod_10 !== got.prod.m10)
                    begin
                        $error("prod_10 expected %0d actual %0d", got.prod.m10, rsp.prod_10);
                        errors++;
                    end
                    if (rsp.prod_11 !== got.prod.m11)
                    begin
                        $error("prod_11 expected %0d actual %0d", got.prod.m11, rsp.prod_11);
                        errors++;
                    end
                    if (rsp.status !== got.status)
                    begin
                        $error("status expected %0d actual %0d", got.status, rsp.status);
                        errors++;
                    end
                end
            end
            pending = answer_fifo.size();
        end
    end

endmodule

// ===== test/range_matrix_product_mod_unit_tb.sv =====
`timescale 1ns / 1ps

module range_matrix_product_mod_unit_tb;
    import rmp_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_write;
    logic [0:0]            cfg_index;
    logic [ENTRY_BITS-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    quiet_cycles;
    bit                    long_hold;
    int                    leaves;

    range_matrix_product_mod_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    range_matrix_product_mod_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial
    begin
        int hold;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = $urandom_range(0, 4);
            if (long_hold)
            begin
                hold      = 400;
                long_hold = 1'b0;
            end
            repeat (hold)
            begin
                rsp_stall <= 1'b1;
                @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input req_t item);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        req_valid <= 1'b0;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ENTRY_BITS'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for all answers plus the worst load still in flight
    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2000)
            @(negedge clk);
    endtask

    function automatic req_t random_item(int n);
        req_t item;
        item = req_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 6)
        begin
            item.action = ACT_QUERY;
            if ($urandom_range(0, 9) != 0)
            begin
                item.range_low  = LEAF_BITS'($urandom_range(0, n - 1));
                item.range_high = LEAF_BITS'($urandom_range(0, n - 1));
                if ($urandom_range(0, 1) && item.range_low > item.range_high)
                    {item.range_low, item.range_high} = {item.range_high, item.range_low};
            end
        end
        else
        begin
            item.action = ACT_LOAD;
            if ($urandom_range(0, 9) != 0)
                item.leaf_index = LEAF_BITS'($urandom_range(0, n - 1));
            case ($urandom_range(0, 5))
                0: {item.entry_00, item.entry_01, item.entry_10, item.entry_11} = '1;
                1: {item.entry_00, item.entry_01, item.entry_10, item.entry_11} = '0;
                default: ;
            endcase
        end
        return item;
    endfunction

    function automatic req_t range_query(int lo, int hi);
        req_t item;
        item            = req_t'({$urandom, $urandom, $urandom});
        item.action     = ACT_QUERY;
        item.range_low  = LEAF_BITS'(lo);
        item.range_high = LEAF_BITS'(hi);
        return item;
    endfunction

    // one setting: new modulus, optional new leaf count and full reload, then directed queries and random items
    task automatic run_phase(input int leaf_cfg, input int mod_cfg, input bit reload,
                             input int rounds, input bit squeeze);
        int   order [$];
        int   j;
        int   t;
        req_t item;
        drain();
        write_reg(CFG_MODULUS, mod_cfg);
        if (reload)
        begin
            write_reg(CFG_LEAF_COUNT, leaf_cfg);
            leaves = leaf_cfg & 16'h7FF;
            if (leaves == 0)
                leaves = 1;
            if (leaves > MAX_LEAVES)
                leaves = MAX_LEAVES;
            order.delete();
            for (int i = 0; i < leaves; i++)
                order = {order, i};
            for (int i = leaves - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            // every leaf in use gets loaded, extremes first
            for (int i = 0; i < leaves; i++)
            begin
                item            = req_t'({$urandom, $urandom, $urandom});
                item.action     = ACT_LOAD;
                item.leaf_index = LEAF_BITS'(order[i]);
                if (i == 0)
                    {item.entry_00, item.entry_01, item.entry_10, item.entry_11} = '1;
                else if (i == 1)
                    {item.entry_00, item.entry_01, item.entry_10, item.entry_11} = '0;
                send_item(item);
            end
        end
        // full range, ends, empty range, out-of-range indexes
        send_item(range_query(0, leaves - 1));
        send_item(range_query(0, 0));
        send_item(range_query(leaves - 1, leaves - 1));
        send_item(range_query(leaves - 1, 0));
        send_item(range_query(1023, 0));
        send_item(range_query(0, 1023));
        if (squeeze)
            long_hold = 1'b1;
        repeat (rounds)
            send_item(random_item(leaves));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_MODULUS;
        cfg_data     = '0;
        long_hold    = 1'b0;
        leaves       = 1024;
        quiet_cycles = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // oversize leaf count clamps to the full tree
        run_phase(1500, 65535, 1'b1, 30, 1'b0);
        // zero leaf count and zero modulus
        run_phase(0, 0, 1'b1, 60, 1'b0);
        run_phase(2, 1, 1'b1, 90, 1'b0);
        run_phase(3, 2, 1'b1, 90, 1'b0);
        run_phase(7, 65521, 1'b1, 90, 1'b1);
        run_phase(16, 65535, 1'b1, 90, 1'b0);
        run_phase(37, $urandom_range(2, 65535), 1'b1, 90, 1'b0);
        run_phase(100, 3, 1'b1, 90, 1'b0);
        // modulus changed over an already loaded tree
        run_phase(100, 65535, 1'b0, 100, 1'b1);

        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2000)
            @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
